/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on clk, disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// trigger in one cycle implies the result in the next
`define ASSERT_NEXT(lbl, trig, res_cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res_cond)) \
    else $error(msg);

`endif

/* hw/rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared constants, codes and types of the bracket balance checker
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int MAX_PAIRS       = 4;
  localparam int REG_BYTES       = 4;
  localparam int PAIR_W          = 2;
  localparam int POS_W           = 20;
  localparam int DEPTH_OUT_W     = 11;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int Q_DEPTH         = 2;
  localparam int Q_AW            = 1;
  localparam int Q_CW            = 2;

  localparam logic [7:0]       ESC_CHAR = 8'h5C;
  localparam logic [POS_W-1:0] POS_MAX  = 20'hFFFFF;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd2;

  typedef struct packed {
    logic                 clear;
    logic                 active;
    logic                 is_close;
    logic                 is_open;
    logic [PAIR_W-1:0]    open_idx;
    logic [REG_BYTES-1:0] close_hit;
    logic [POS_W-1:0]     offset;
  } bbc_item_t;

  typedef struct packed {
    logic       full;
    logic [1:0] err;
  } bbc_stat_t;

endpackage

/* hw/rtl/bbc_if.sv */
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channel interfaces: character input, result output, config
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface bbc_out_if;
  logic                               valid;
  logic                               ready;
  logic [bbc_pkg::DEPTH_OUT_W-1:0]    depth_now;
  logic [bbc_pkg::POS_W-1:0]          char_offset;
  logic [1:0]                         status;
  logic                               balanced;

  modport source (output valid, output depth_now, output char_offset, output status,
                  output balanced, input ready);
  modport sink   (input valid, input depth_now, input char_offset, input status,
                  input balanced, output ready);
endinterface

interface bbc_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bbc_pkg::CFG_IDX_W-1:0]    index;
  logic [bbc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front
// Accepts character requests, tracks escape and offset, classifies delimiters
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic                clk,
  input  logic                rst,
  bbc_in_if.sink              src,
  bbc_cfg_if.sink             cfg,
  input  logic                q_full,
  output logic                q_push,
  output bbc_pkg::bbc_item_t  q_item
);

  logic [bbc_pkg::CFG_DATA_W-1:0] open_chars;
  logic [bbc_pkg::CFG_DATA_W-1:0] close_chars;
  logic [2:0]                     pair_count;
  logic                           esc;
  logic                           esc_next;
  logic [bbc_pkg::POS_W-1:0]      pos;
  logic [bbc_pkg::POS_W-1:0]      pos_next;
  logic [2:0]                     n_used;
  logic [bbc_pkg::REG_BYTES-1:0]  open_hit;
  logic [bbc_pkg::REG_BYTES-1:0]  close_hit;
  logic [bbc_pkg::REG_BYTES-1:0]  pair_mask;
  logic [bbc_pkg::PAIR_W-1:0]     open_idx;

  assign cfg.ready = 1'b1;
  assign src.ready = !q_full;
  assign q_push    = src.valid && src.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_chars  <= '0;
      close_chars <= '0;
      pair_count  <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        bbc_pkg::REG_OPEN:  open_chars  <= cfg.data;
        bbc_pkg::REG_CLOSE: close_chars <= cfg.data;
        bbc_pkg::REG_COUNT: pair_count  <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  // pairs in use, clamped
  always_comb begin
    n_used = pair_count;
    if (int'(n_used) > bbc_pkg::MAX_PAIRS) n_used = 3'(bbc_pkg::MAX_PAIRS);
    if (int'(n_used) > bbc_pkg::REG_BYTES) n_used = 3'(bbc_pkg::REG_BYTES);
  end

  always_comb begin
    open_idx = '0;
    for (int k = 0; k < bbc_pkg::REG_BYTES; k++) begin
      pair_mask[k] = (3'(k) < n_used);
      open_hit[k]  = (open_chars[k*8 +: 8] == src.ch) && pair_mask[k];
      close_hit[k] = (close_chars[k*8 +: 8] == src.ch);
    end
    // lowest matching opener wins
    for (int k = bbc_pkg::REG_BYTES - 1; k >= 0; k--) begin
      if (open_hit[k]) open_idx = bbc_pkg::PAIR_W'(k);
    end
  end

  always_comb begin
    q_item.clear     = src.op;
    q_item.active    = !src.op && !esc && (src.ch != bbc_pkg::ESC_CHAR);
    q_item.is_close  = |(close_hit & pair_mask);
    q_item.is_open   = |open_hit;
    q_item.open_idx  = open_idx;
    q_item.close_hit = close_hit;
    q_item.offset    = src.op ? '0 : pos;
    if (src.op) begin
      esc_next = 1'b0;
      pos_next = '0;
    end else begin
      esc_next = esc ? 1'b0 : (src.ch == bbc_pkg::ESC_CHAR);
      pos_next = (pos == bbc_pkg::POS_MAX) ? pos : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc <= 1'b0;
      pos <= '0;
    end else if (q_push) begin
      esc <= esc_next;
      pos <= pos_next;
    end
  end

endmodule

/* hw/rtl/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue
// Short FIFO of classified requests between front and back
// ----------------------------------------------------------------------------
module bbc_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bbc_pkg::bbc_item_t  push_item,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output bbc_pkg::bbc_item_t  head_item
);

  bbc_pkg::bbc_item_t             entries [bbc_pkg::Q_DEPTH];
  logic [bbc_pkg::Q_AW-1:0]       wp;
  logic [bbc_pkg::Q_AW-1:0]       rp;
  logic [bbc_pkg::Q_CW-1:0]       count;

  assign full       = (count == bbc_pkg::Q_CW'(bbc_pkg::Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= (wp == bbc_pkg::Q_AW'(bbc_pkg::Q_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == bbc_pkg::Q_AW'(bbc_pkg::Q_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* hw/rtl/bbc_back.sv */
// ----------------------------------------------------------------------------
// bbc_back
// Closer stack with top-of-stack register, error tracking, result register
// ----------------------------------------------------------------------------
module bbc_back #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  bbc_pkg::bbc_item_t  q_item,
  output logic                q_pop,
  bbc_out_if.source           res,
  output bbc_pkg::bbc_stat_t  stat
);

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [DW-1:0] FULL = DW'(STACK_DEPTH);

  logic [bbc_pkg::PAIR_W-1:0] mem [STACK_DEPTH];
  logic [DW-1:0]              depth;
  logic [DW-1:0]              depth_next;
  logic [bbc_pkg::PAIR_W-1:0] tos;
  logic [bbc_pkg::PAIR_W-1:0] tos_next;
  logic [1:0]                 err;
  logic [1:0]                 err_next;
  logic                       wr_en;
  logic [DW-1:0]              wr_sum;
  logic [DW-1:0]              rd_sum;
  logic [bbc_pkg::PAIR_W-1:0] rd_q;
  logic                       byp_q;
  logic [bbc_pkg::PAIR_W-1:0] byp_d;
  logic [bbc_pkg::PAIR_W-1:0] second;
  logic                       ovalid;
  logic [DW+10:0]             depth_ext;

  assign q_pop  = q_valid && (!ovalid || res.ready);
  assign second = byp_q ? byp_d : rd_q;

  always_comb begin
    depth_next = depth;
    tos_next   = tos;
    err_next   = err;
    wr_en      = 1'b0;
    if (q_pop) begin
      priority if (q_item.clear) begin
        depth_next = '0;
        err_next   = bbc_pkg::ST_OK;
      end else if (q_item.active && (err == bbc_pkg::ST_OK)) begin
        priority if (q_item.is_close) begin
          if ((depth != '0) && q_item.close_hit[tos]) begin
            depth_next = depth - 1'b1;
            tos_next   = second;
          end else begin
            err_next = bbc_pkg::ST_MISMATCH;
          end
        end else if (q_item.is_open) begin
          if (depth == FULL) begin
            err_next = bbc_pkg::ST_OVERFLOW;
          end else begin
            depth_next = depth + 1'b1;
            tos_next   = q_item.open_idx;
            wr_en      = (depth != '0);
          end
        end else begin
        end
      end else begin
      end
    end
  end

  // entries below the top live in memory, top in tos
  assign wr_sum = depth - 1'b1;
  assign rd_sum = depth_next - DW'(2);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_sum[AW-1:0]] <= tos;
    rd_q <= mem[rd_sum[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth  <= '0;
      err    <= bbc_pkg::ST_OK;
      byp_q  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      depth <= depth_next;
      err   <= err_next;
      byp_q <= wr_en;
      if (q_pop) ovalid <= 1'b1;
      else if (res.ready) ovalid <= 1'b0;
    end
  end

  assign depth_ext = {11'b0, depth_next};

  always_ff @(posedge clk) begin
    tos   <= tos_next;
    byp_d <= tos;
    if (q_pop) begin
      res.depth_now   <= depth_ext[bbc_pkg::DEPTH_OUT_W-1:0];
      res.char_offset <= q_item.offset;
      res.status      <= err_next;
      res.balanced    <= (depth_next == '0) && (err_next == bbc_pkg::ST_OK);
    end
  end

  assign res.valid = ovalid;
  assign stat.full = (depth == FULL);
  assign stat.err  = err;

endmodule

/* hw/rtl/bracket_balance_checker.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Delimiter nesting checker over a character stream
//
// src carries one request per character: op (0 process, 1 clear) and ch.
// cfg writes open_chars (index 0), close_chars (1) and pair_count (2); it is
// always ready. The user must write it only while no request is in flight;
// the block does not enforce this. res returns one result per request:
// depth_now, char_offset, status and balanced, in request order.
// A request passes through the queue entry and the result register on its way
// to res. Throughput is one request per cycle while res is ready, set by the
// stack update in the back end: the top entry is held in a register and the
// entry below it is read ahead from the stack memory every cycle.
// A two-entry queue sits between front and back, followed by a result
// register; when res stalls the queue fills and src.ready drops, and no
// result is lost.
// rst clears the config, queue, valid flag, stack depth, escape, offset and
// error at once; no clearing pass over the stack memory is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bracket_balance_checker #(
  parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    src,
  bbc_out_if.source res,
  bbc_cfg_if.sink   cfg
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  bbc_pkg::bbc_item_t  q_in;
  bbc_pkg::bbc_item_t  q_head;
  bbc_pkg::bbc_stat_t  stat;

  bbc_front u_front (
    .clk    (clk),
    .rst    (rst),
    .src    (src),
    .cfg    (cfg),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  bbc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  bbc_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_item  (q_head),
    .q_pop   (q_pop),
    .res     (res),
    .stat    (stat)
  );

  `ASSERT_CLK(a_balanced_flag, !res.valid || (res.balanced == ((res.depth_now == '0) && (res.status == bbc_pkg::ST_OK))), "balanced flag disagrees with depth and status")
  `ASSERT_CLK(a_overflow_full, (stat.err != bbc_pkg::ST_OVERFLOW) || stat.full, "overflow status without a full stack")
  `ASSERT_NEXT(a_clear_resets, q_pop && q_head.clear, (stat.err == bbc_pkg::ST_OK) && !stat.full, "clear request did not reset error state")

endmodule
